// ===== hdl/lzssd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_pkg
// Shared types and constants of the LZSS stream decompressor.
// ----------------------------------------------------------------------------
package lzssd_pkg;

   localparam int CountWidth  = 24;
   localparam int OffsetWidth = 12;
   localparam int LengthWidth = 5;
   localparam int MinMatch    = 3;

   localparam logic [CountWidth-1:0] LimitReset = 24'hFFFFFF;

   typedef enum logic [1:0] {
      PH_FLAG,
      PH_TOKEN,
      PH_REF2
   } phase_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_LIT,
      KIND_REF
   } kind_type;

   typedef enum logic {
      ENG_IDLE,
      ENG_COPY
   } eng_state_type;

   // one classified input word, as queued between parser and engine
   typedef struct packed {
      kind_type    kind;
      logic        start;
      logic        last;
      logic [7:0]  held;
      logic [7:0]  data;
   } cmd_type;

endpackage

// ===== hdl/lzss_stream_decompressor_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_top
// LZSS decompressor, 12-bit offsets, byte stream in, decoded bytes out.
// ----------------------------------------------------------------------------
// An accepted word passes through the command queue and the output register
//   before its decoded byte is valid; a reference also waits for the window read.
// Throughput: a reference copies from the window one byte per cycle while
//   the output can take it; no queue entry is popped during the copy.
// Reset is synchronous. The window RAM is not cleared: a per-stream fill
//   mark makes unwritten entries read as zero, so no clearing pass is run.
module lzss_stream_decompressor_top #(
   parameter int WINDOW_SIZE = 4096,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic        clock,
   input  logic        reset,
   // request words
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] in_byte
   input  logic        req_tuser,   // [0] stream_start
   input  logic        req_tlast,   // stream_end
   // decoded bytes
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] out_byte, [31:8] produced_count
   output logic        rsp_tuser,   // [0] limit_reached
   output logic        rsp_tlast,   // run_last
   // output limit register
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [23:0] csr_data
);

   logic                cmd_valid;
   lzssd_pkg::cmd_type  cmd;
   logic                head_valid;
   lzssd_pkg::cmd_type  head_cmd;
   logic                pop;
   logic [7:0]          out_byte;
   logic [lzssd_pkg::CountWidth-1:0] out_count;

   lzssd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_byte   (req_tdata),
      .in_start  (req_tuser),
      .in_end    (req_tlast),
      .cmd_valid (cmd_valid),
      .cmd       (cmd)
   );

   lzssd_cmd_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (cmd_valid),
      .push_ready (req_tready),
      .push_cmd   (cmd),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop)
   );

   lzssd_engine #(
      .WINDOW_SIZE (WINDOW_SIZE)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_cmd   (head_cmd),
      .pop        (pop),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .rsp_valid  (rsp_tvalid),
      .rsp_ready  (rsp_tready),
      .rsp_byte   (out_byte),
      .rsp_last   (rsp_tlast),
      .rsp_limit  (rsp_tuser),
      .rsp_count  (out_count)
   );

   assign rsp_tdata = {out_count, out_byte};

endmodule

// ===== hdl/lzssd_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_ram
// Simple dual-port RAM, one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module lzssd_ram #(
   parameter int DATA_WIDTH = 8,
   parameter int DEPTH      = 4096,
   localparam int AddrWidth = $clog2(DEPTH)
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic [AddrWidth-1:0]  wr_addr,
   input  logic [DATA_WIDTH-1:0] wr_data,
   input  logic [AddrWidth-1:0]  rd_addr,
   output logic [DATA_WIDTH-1:0] rd_data
);

   logic [DATA_WIDTH-1:0] mem_ff [DEPTH];
   logic [DATA_WIDTH-1:0] rd_data_ff;

   // read-first: a read of the address being written returns the old data
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/lzssd_cmd_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_cmd_fifo
// Short command queue between the parser and the copy engine.
// ----------------------------------------------------------------------------
module lzssd_cmd_fifo #(
   parameter int DEPTH      = 4,
   localparam int PtrWidth  = $clog2(DEPTH),
   localparam int CntWidth  = $clog2(DEPTH + 1)
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  lzssd_pkg::cmd_type push_cmd,
   output logic              head_valid,
   output lzssd_pkg::cmd_type head_cmd,
   input  logic              pop
);

   localparam logic [PtrWidth-1:0] LastPtr = PtrWidth'(DEPTH - 1);
   localparam logic [CntWidth-1:0] FullCnt = CntWidth'(DEPTH);

   lzssd_pkg::cmd_type entry_ff [DEPTH];
   logic [PtrWidth-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PtrWidth-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CntWidth-1:0] count_ff, count_in;
   logic                do_push;
   logic                do_pop;

   assign push_ready = (count_ff != FullCnt);
   assign head_valid = (count_ff != '0);
   assign head_cmd   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LastPtr) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LastPtr) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== hdl/lzssd_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_parser
// Token parser: tracks flag bytes and reference halves, tags each word.
// ----------------------------------------------------------------------------
module lzssd_parser (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  logic               in_ready,
   input  logic [7:0]         in_byte,
   input  logic               in_start,
   input  logic               in_end,
   output logic               cmd_valid,
   output lzssd_pkg::cmd_type cmd
);

   lzssd_pkg::phase_type phase_ff, phase_in, phase_eff;
   logic [7:0] flags_ff, flags_in;
   logic [2:0] idx_ff, idx_in;
   logic [7:0] held_ff, held_in;
   logic       accept;

   assign accept    = in_valid && in_ready;
   assign cmd_valid = in_valid;
   // a stream start restarts parsing on this very word
   assign phase_eff = in_start ? lzssd_pkg::PH_FLAG : phase_ff;

   always_comb begin
      phase_in  = phase_ff;
      flags_in  = flags_ff;
      idx_in    = idx_ff;
      held_in   = held_ff;
      cmd.kind  = lzssd_pkg::KIND_NONE;
      cmd.start = in_start;
      cmd.last  = in_end;
      cmd.held  = held_ff;
      cmd.data  = in_byte;
      unique case (phase_eff)
         lzssd_pkg::PH_FLAG: begin
            flags_in = in_byte;
            idx_in   = '0;
            phase_in = lzssd_pkg::PH_TOKEN;
         end
         lzssd_pkg::PH_TOKEN: begin
            if (flags_ff[idx_ff]) begin
               cmd.kind = lzssd_pkg::KIND_LIT;
               idx_in   = idx_ff + 1'b1;
               phase_in = (idx_ff == 3'd7) ? lzssd_pkg::PH_FLAG : lzssd_pkg::PH_TOKEN;
            end else begin
               held_in  = in_byte;
               phase_in = lzssd_pkg::PH_REF2;
            end
         end
         lzssd_pkg::PH_REF2: begin
            cmd.kind = lzssd_pkg::KIND_REF;
            idx_in   = idx_ff + 1'b1;
            phase_in = (idx_ff == 3'd7) ? lzssd_pkg::PH_FLAG : lzssd_pkg::PH_TOKEN;
         end
         default: begin
            phase_in = lzssd_pkg::PH_FLAG;
         end
      endcase
      if (!accept) begin
         phase_in = phase_ff;
         flags_in = flags_ff;
         idx_in   = idx_ff;
         held_in  = held_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= lzssd_pkg::PH_FLAG;
      end else begin
         phase_ff <= phase_in;
      end
   end

   always_ff @(posedge clock) begin
      flags_ff <= flags_in;
      idx_ff   <= idx_in;
      held_ff  <= held_in;
   end

endmodule

// ===== hdl/lzssd_engine.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzssd_engine
// Copy engine: writes literals into the history window, copies references
// byte by byte, keeps the stream counters and the output register.
// ----------------------------------------------------------------------------
module lzssd_engine #(
   parameter int WINDOW_SIZE = 4096,
   localparam int AddrWidth  = $clog2(WINDOW_SIZE)
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                head_valid,
   input  lzssd_pkg::cmd_type                  head_cmd,
   output logic                                pop,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [lzssd_pkg::CountWidth-1:0]    csr_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic [7:0]                          rsp_byte,
   output logic                                rsp_last,
   output logic                                rsp_limit,
   output logic [lzssd_pkg::CountWidth-1:0]    rsp_count
);

   localparam int CW = lzssd_pkg::CountWidth;
   localparam int OW = lzssd_pkg::OffsetWidth;
   localparam int LW = lzssd_pkg::LengthWidth;
   localparam logic [AddrWidth-1:0] LastAddr   = AddrWidth'(WINDOW_SIZE - 1);
   localparam logic [AddrWidth:0]   WinSizeExt = (AddrWidth + 1)'(WINDOW_SIZE);

   lzssd_pkg::eng_state_type state_ff, state_in;
   logic [AddrWidth-1:0] wp_ff, wp_in, eff_wp, wp_step;
   logic                 wrapped_ff, wrapped_in, eff_wrapped, wp_wraps;
   logic [CW-1:0]        prod_ff, prod_in, eff_prod, prod_inc;
   logic                 done_ff, done_in, eff_done;
   logic [CW-1:0]        limit_ff;
   logic [AddrWidth-1:0] src_ff, src_in, src_step, ref_src;
   logic [LW-1:0]        rem_ff, rem_in;
   logic                 end_ff, end_in;
   logic                 rd_valid_ff, byp_ff;
   logic [7:0]           byp_data_ff;
   logic                 starting, hit, at_limit, can_emit;
   logic [OW-1:0]        ref_offset;
   logic [AddrWidth:0]   ref_diff;
   logic [AddrWidth-1:0] rd_addr;
   logic [7:0]           ram_rd, win_byte;
   logic                 emit, emit_last;
   logic [7:0]           emit_byte;
   logic                 rsp_valid_ff;
   logic [7:0]           rsp_byte_ff;
   logic                 rsp_last_ff, rsp_limit_ff;
   logic [CW-1:0]        rsp_count_ff;

   // a start word clears the stream state before it is carried out
   assign starting    = (state_ff == lzssd_pkg::ENG_IDLE) && head_valid && head_cmd.start;
   assign eff_wp      = starting ? '0 : wp_ff;
   assign eff_wrapped = starting ? 1'b0 : wrapped_ff;
   assign eff_prod    = starting ? '0 : prod_ff;
   assign eff_done    = starting ? 1'b0 : done_ff;

   assign prod_inc = eff_prod + 1'b1;
   assign hit      = (prod_inc == limit_ff);
   assign at_limit = (eff_prod >= limit_ff);
   assign can_emit = !rsp_valid_ff || rsp_ready;

   assign wp_wraps = (eff_wp == LastAddr);
   assign wp_step  = wp_wraps ? '0 : eff_wp + 1'b1;
   assign src_step = (src_ff == LastAddr) ? '0 : src_ff + 1'b1;

   // offset zero behaves as offset one
   always_comb begin
      ref_offset = {head_cmd.data[7:4], head_cmd.held};
      if (ref_offset == '0) begin
         ref_offset = OW'(1);
      end
   end
   assign ref_diff = {1'b0, eff_wp} - (AddrWidth + 1)'(ref_offset);
   assign ref_src  = ref_diff[AddrWidth] ? AddrWidth'(ref_diff + WinSizeExt)
                                         : ref_diff[AddrWidth-1:0];

   // entries past the fill mark of this stream read as zero
   assign win_byte = byp_ff ? byp_data_ff : (rd_valid_ff ? ram_rd : 8'h00);

   always_comb begin
      state_in   = state_ff;
      wp_in      = wp_ff;
      wrapped_in = wrapped_ff;
      prod_in    = prod_ff;
      done_in    = done_ff;
      src_in     = src_ff;
      rem_in     = rem_ff;
      end_in     = end_ff;
      pop        = 1'b0;
      emit       = 1'b0;
      emit_byte  = head_cmd.data;
      emit_last  = 1'b1;
      rd_addr    = src_ff;
      unique case (state_ff)
         lzssd_pkg::ENG_IDLE: begin
            if (head_valid) begin
               wp_in      = eff_wp;
               wrapped_in = eff_wrapped;
               prod_in    = eff_prod;
               done_in    = eff_done;
               priority if (eff_done) begin
                  pop = 1'b1;
               end else if (at_limit) begin
                  pop     = 1'b1;
                  done_in = 1'b1;
               end else begin
                  unique case (head_cmd.kind)
                     lzssd_pkg::KIND_LIT: begin
                        if (can_emit) begin
                           pop        = 1'b1;
                           emit       = 1'b1;
                           wp_in      = wp_step;
                           wrapped_in = eff_wrapped || wp_wraps;
                           prod_in    = prod_inc;
                           done_in    = head_cmd.last || hit;
                        end
                     end
                     lzssd_pkg::KIND_REF: begin
                        pop      = 1'b1;
                        rd_addr  = ref_src;
                        src_in   = ref_src;
                        rem_in   = LW'(head_cmd.data[3:0]) + LW'(lzssd_pkg::MinMatch);
                        end_in   = head_cmd.last;
                        state_in = lzssd_pkg::ENG_COPY;
                     end
                     default: begin
                        pop     = 1'b1;
                        done_in = head_cmd.last;
                     end
                  endcase
               end
            end
         end
         lzssd_pkg::ENG_COPY: begin
            if (can_emit) begin
               emit       = 1'b1;
               emit_byte  = win_byte;
               emit_last  = (rem_ff == LW'(1)) || hit;
               wp_in      = wp_step;
               wrapped_in = eff_wrapped || wp_wraps;
               prod_in    = prod_inc;
               rem_in     = rem_ff - 1'b1;
               if (emit_last) begin
                  state_in = lzssd_pkg::ENG_IDLE;
                  done_in  = end_ff || hit;
               end else begin
                  rd_addr = src_step;
                  src_in  = src_step;
               end
            end
         end
         default: begin
            state_in = lzssd_pkg::ENG_IDLE;
         end
      endcase
   end

   lzssd_ram #(
      .DATA_WIDTH (8),
      .DEPTH      (WINDOW_SIZE)
   ) u_window (
      .clock   (clock),
      .wr_en   (emit),
      .wr_addr (eff_wp),
      .wr_data (emit_byte),
      .rd_addr (rd_addr),
      .rd_data (ram_rd)
   );

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= lzssd_pkg::ENG_IDLE;
         wp_ff        <= '0;
         wrapped_ff   <= 1'b0;
         prod_ff      <= '0;
         done_ff      <= 1'b1;
         limit_ff     <= lzssd_pkg::LimitReset;
         rsp_valid_ff <= 1'b0;
         byp_ff       <= 1'b0;
         rd_valid_ff  <= 1'b0;
      end else begin
         state_ff   <= state_in;
         wp_ff      <= wp_in;
         wrapped_ff <= wrapped_in;
         prod_ff    <= prod_in;
         done_ff    <= done_in;
         if (csr_valid) begin
            limit_ff <= csr_data;
         end
         if (emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         // forward a byte written in the same cycle as its read was issued
         byp_ff      <= emit && (eff_wp == rd_addr);
         rd_valid_ff <= eff_wrapped || (rd_addr < eff_wp);
      end
   end

   always_ff @(posedge clock) begin
      src_ff      <= src_in;
      rem_ff      <= rem_in;
      end_ff      <= end_in;
      byp_data_ff <= emit_byte;
      if (emit) begin
         rsp_byte_ff  <= emit_byte;
         rsp_last_ff  <= emit_last;
         rsp_limit_ff <= hit;
         rsp_count_ff <= prod_inc;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_byte  = rsp_byte_ff;
   assign rsp_last  = rsp_last_ff;
   assign rsp_limit = rsp_limit_ff;
   assign rsp_count = rsp_count_ff;

endmodule

// ===== sim/lzss_decode_check_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_decode_check_pkg
// Expected-byte tracker for the LZSS stream decompressor bench: decodes
// each accepted word alongside the block and checks the decoded words.
// ----------------------------------------------------------------------------
package lzss_decode_check_pkg;

   typedef struct packed {
      logic [7:0]                       out_byte;
      logic                             run_last;
      logic                             limit_hit;
      logic [lzssd_pkg::CountWidth-1:0] count;
   } decoded_byte_type;

   class decoded_byte_tracker;
      logic [7:0]                       window [4096];
      logic [11:0]                      wr_pos;
      logic [7:0]                       flags;
      int unsigned                      bit_idx;
      lzssd_pkg::phase_type             phase;
      logic [7:0]                       held;
      logic [lzssd_pkg::CountWidth-1:0] produced;
      bit                               done;
      logic [lzssd_pkg::CountWidth-1:0] limit;
      decoded_byte_type                 pending_bytes[$];
      int unsigned                      fails;

      function new();
         clear_stream();
         done  = 1'b1;
         limit = lzssd_pkg::LimitReset;
         fails = 0;
      endfunction

      function void clear_stream();
         foreach (window[i]) window[i] = '0;
         wr_pos   = '0;
         flags    = '0;
         bit_idx  = 8;
         phase    = lzssd_pkg::PH_FLAG;
         held     = '0;
         produced = '0;
      endfunction

      function void set_limit(logic [lzssd_pkg::CountWidth-1:0] value);
         limit = value;
      endfunction

      function int unsigned pending();
         return pending_bytes.size();
      endfunction

      function void record_failure(string what);
         fails++;
         if (fails <= 10) $display("%s", what);
      endfunction

      function void push_byte(logic [7:0] value);
         decoded_byte_type e;
         window[wr_pos] = value;
         wr_pos++;
         produced++;
         e.out_byte  = value;
         e.run_last  = 1'b0;
         e.limit_hit = (produced == limit);
         e.count     = produced;
         pending_bytes.push_back(e);
      endfunction

      function void next_token();
         bit_idx++;
         phase = (bit_idx >= 8) ? lzssd_pkg::PH_FLAG : lzssd_pkg::PH_TOKEN;
      endfunction

      // decode one accepted request word
      function void note_word(logic [7:0] b, logic start, logic stream_end);
         int unsigned      prior_count;
         int unsigned      length;
         int unsigned      i;
         logic [11:0]      offset;
         logic [11:0]      src;
         decoded_byte_type e;
         prior_count = pending_bytes.size();
         if (start) begin
            clear_stream();
            done = 1'b0;
         end
         if (done) return;
         if (produced >= limit) begin
            done = 1'b1;
            return;
         end
         unique case (phase)
            lzssd_pkg::PH_FLAG: begin
               flags   = b;
               bit_idx = 0;
               phase   = lzssd_pkg::PH_TOKEN;
            end
            lzssd_pkg::PH_TOKEN: begin
               if (flags[bit_idx % 8]) begin
                  push_byte(b);
                  next_token();
               end else begin
                  held  = b;
                  phase = lzssd_pkg::PH_REF2;
               end
            end
            default: begin
               offset = {b[7:4], held};
               length = b[3:0] + lzssd_pkg::MinMatch;
               if (offset == 0) offset = 1;
               // byte-wise copy, so overlapping references repeat
               for (i = 0; i < length && produced < limit; i++) begin
                  src = wr_pos - offset;
                  push_byte(window[src]);
               end
               next_token();
            end
         endcase
         if (pending_bytes.size() > prior_count) begin
            e = pending_bytes.pop_back();
            e.run_last = 1'b1;
            pending_bytes.push_back(e);
         end
         if (stream_end || produced >= limit) done = 1'b1;
      endfunction

      function void check_byte(logic [7:0] out_byte, logic run_last, logic limit_hit,
                               logic [lzssd_pkg::CountWidth-1:0] count);
         decoded_byte_type e;
         if (pending_bytes.size() == 0) begin
            record_failure($sformatf("unexpected decoded byte %02h count %0d", out_byte, count));
            return;
         end
         e = pending_bytes.pop_front();
         if (out_byte !== e.out_byte || run_last !== e.run_last ||
             limit_hit !== e.limit_hit || count !== e.count)
            record_failure($sformatf(
               "mismatch: got byte %02h last %0b limit %0b count %0d, want %02h %0b %0b %0d",
               out_byte, run_last, limit_hit, count,
               e.out_byte, e.run_last, e.limit_hit, e.count));
      endfunction

      function void flag_leftovers();
         if (pending_bytes.size() > 0)
            record_failure($sformatf("%0d decoded bytes never arrived", pending_bytes.size()));
      endfunction
   endclass

endpackage

// ===== sim/lzss_stream_decompressor_top_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lzss_stream_decompressor_top_test
// Drives compressed streams into the decompressor with random gaps and
// back-pressure, under several output limits, and checks every decoded word.
// ----------------------------------------------------------------------------
module lzss_stream_decompressor_top_test;

   localparam int StreamWords = 280;
   localparam int DrainCycles = 40;

   typedef enum int {
      IDLE_NONE,
      IDLE_SENDER,
      IDLE_RECEIVER,
      IDLE_BOTH
   } idle_mode_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [7:0]  req_tdata;   // [7:0] in_byte
   logic        req_tuser;   // [0] stream_start
   logic        req_tlast;   // stream_end
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [31:0] rsp_tdata;   // [7:0] out_byte, [31:8] produced_count
   logic        rsp_tuser;   // [0] limit_reached
   logic        rsp_tlast;   // run_last
   logic        csr_valid;
   logic        csr_ready;
   logic [23:0] csr_data;

   idle_mode_type       idle_mode   = IDLE_NONE;
   int unsigned         hold_cycles = 0;
   int unsigned         words_sent  = 0;
   lzss_decode_check_pkg::decoded_byte_tracker decode_tracker;

   lzss_stream_decompressor_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("RESULT: ERROR");
      $finish;
   end

   // receiver: random stalls per phase, plus a long hold-off on request
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (reset) begin
            rsp_tready = 1'b0;
         end else if (hold_cycles > 0) begin
            rsp_tready = 1'b0;
            hold_cycles--;
         end else begin
            rsp_tready = !((idle_mode == IDLE_RECEIVER && $urandom_range(99) < 56) ||
                           (idle_mode == IDLE_BOTH && $urandom_range(99) < 15));
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready)
         decode_tracker.check_byte(rsp_tdata[7:0], rsp_tlast, rsp_tuser, rsp_tdata[31:8]);
   end

   task automatic send_word(logic [7:0] b, logic start, logic stream_end);
      @(negedge clock);
      while ((idle_mode == IDLE_SENDER && $urandom_range(99) < 56) ||
             (idle_mode == IDLE_BOTH && $urandom_range(99) < 15)) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tdata  = b;
      req_tuser  = start;
      req_tlast  = stream_end;
      do @(posedge clock); while (!req_tready);
      decode_tracker.note_word(b, start, stream_end);
   endtask

   // stop sending, wait for every decoded word, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (decode_tracker.pending() != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic write_limit(logic [23:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      decode_tracker.set_limit(value);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // mostly well-formed streams; some cut at a random word, some garbage
   task automatic send_random_stream();
      logic [7:0]  words[$];
      logic [7:0]  flag_byte;
      logic [11:0] off;
      logic [3:0]  len_code;
      int unsigned guess;
      int unsigned reach;
      int unsigned groups;
      int unsigned cut;
      int unsigned g;
      int unsigned k;
      int unsigned r;
      guess = 0;
      if ($urandom_range(99) < 5) begin
         repeat ($urandom_range(2, 12)) words.push_back(8'($urandom_range(255)));
      end else begin
         groups = $urandom_range(1, 3);
         for (g = 0; g < groups; g++) begin
            flag_byte = 8'($urandom_range(255));
            words.push_back(flag_byte);
            for (k = 0; k < 8; k++) begin
               if (flag_byte[k]) begin
                  words.push_back(8'($urandom_range(255)));
                  guess++;
               end else begin
                  r = $urandom_range(99);
                  reach = (guess < 1) ? 1 : ((guess > 64) ? 64 : guess);
                  if (r < 10) off = '0;
                  else if (r < 25) off = 12'($urandom_range(4095));
                  else off = 12'($urandom_range(1, reach));
                  len_code = 4'($urandom_range(15));
                  words.push_back(off[7:0]);
                  words.push_back({off[11:8], len_code});
                  guess += len_code + lzssd_pkg::MinMatch;
               end
            end
         end
         if ($urandom_range(99) < 30) begin
            cut = $urandom_range(1, words.size());
            while (words.size() > cut) void'(words.pop_back());
         end
      end
      foreach (words[i]) send_word(words[i], i == 0, i == words.size() - 1);
      words_sent += words.size();
      // stray words after the end are ignored by the block
      if ($urandom_range(9) == 0)
         repeat ($urandom_range(1, 3))
            send_word(8'($urandom_range(255)), 1'b0, 1'($urandom_range(1)));
   endtask

   initial begin
      idle_mode_type modes  [4];
      logic [23:0]   limits [4];
      decode_tracker = new();
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tdata  = '0;
      req_tuser  = 1'b0;
      req_tlast  = 1'b0;
      csr_valid  = 1'b0;
      csr_data   = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // word before any start: ignored
      send_word(8'h5A, 1'b0, 1'b0);
      // lit, ref, lit, ref, ref, ref...
      send_word(8'h05, 1'b1, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);
      send_word(8'h00, 1'b0, 1'b0);   // offset zero reads as one, longest run
      send_word(8'h0F, 1'b0, 1'b0);
      send_word(8'h80, 1'b0, 1'b0);
      send_word(8'hFF, 1'b0, 1'b0);   // farthest offset: cleared window
      send_word(8'hF0, 1'b0, 1'b0);
      send_word(8'h02, 1'b0, 1'b0);
      send_word(8'h01, 1'b0, 1'b0);
      send_word(8'h10, 1'b0, 1'b1);   // reference cut short by the end
      send_word(8'h33, 1'b0, 1'b0);   // after end: ignored
      send_word(8'h01, 1'b1, 1'b1);   // start and end on a flag word
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h12, 1'b0, 1'b1);

      wait_idle();
      write_limit(24'd0);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h77, 1'b0, 1'b1);

      // limit hit inside a reference
      wait_idle();
      write_limit(24'd7);
      send_word(8'h01, 1'b1, 1'b0);
      send_word(8'hAB, 1'b0, 1'b0);
      send_word(8'h01, 1'b0, 1'b0);
      send_word(8'h0F, 1'b0, 1'b0);
      send_word(8'h44, 1'b0, 1'b1);

      // limit lowered below the count mid-stream
      wait_idle();
      write_limit(lzssd_pkg::LimitReset);
      send_word(8'hFF, 1'b1, 1'b0);
      send_word(8'h01, 1'b0, 1'b0);
      send_word(8'h02, 1'b0, 1'b0);
      send_word(8'h03, 1'b0, 1'b0);
      wait_idle();
      write_limit(24'd2);
      send_word(8'h04, 1'b0, 1'b0);
      send_word(8'h05, 1'b0, 1'b1);

      modes  = '{IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH};
      limits = '{lzssd_pkg::LimitReset, 24'($urandom_range(1, 40)),
                 lzssd_pkg::LimitReset, 24'($urandom_range(0, 24'hFFFFFF))};
      words_sent = 0;
      for (int p = 0; p < 4; p++) begin
         wait_idle();
         write_limit(limits[p]);
         idle_mode = modes[p];
         if (modes[p] == IDLE_RECEIVER) hold_cycles = 300;
         while (words_sent < (p + 1) * StreamWords / 4) begin
            send_random_stream();
            if ($urandom_range(9) == 0) wait_idle();
         end
      end

      idle_mode = IDLE_NONE;
      wait_idle();
      decode_tracker.flag_leftovers();
      if (decode_tracker.fails == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

// ===== sim.f =====
hdl/lzssd_pkg.sv
hdl/lzssd_ram.sv
hdl/lzssd_cmd_fifo.sv
hdl/lzssd_parser.sv
hdl/lzssd_engine.sv
hdl/lzss_stream_decompressor_top.sv
sim/lzss_decode_check_pkg.sv
sim/lzss_stream_decompressor_top_test.sv
